/* sv/krbc_pkg.sv */
package krbc_pkg;

    localparam int unsigned KEY_MAX_DEF = 32;
    localparam int unsigned KEY_BYTES   = 32;
    localparam int unsigned KEY_WORDS   = 4;

    localparam logic [15:0] GEN_INIT   = 16'hAAAA;
    localparam logic [15:0] GEN_STEP   = 16'd16;
    localparam logic [5:0]  KEY_LEN_MIN = 6'd2;
    localparam logic [5:0]  KEY_LEN_RST = 6'd2;

    localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
    localparam logic [2:0] REG_KEY_WORD_0 = 3'd1;
    localparam logic [2:0] REG_KEY_WORD_1 = 3'd2;
    localparam logic [2:0] REG_KEY_WORD_2 = 3'd3;
    localparam logic [2:0] REG_KEY_WORD_3 = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIX,
        ST_ROUND
    } krbc_state_t;

    function automatic logic [15:0] rotr16(input logic [15:0] v, input logic [3:0] n);
        logic [31:0] dbl;
        dbl = {v, v} >> n;
        return dbl[15:0];
    endfunction

endpackage

/* sv/krbc_round.sv */
module krbc_round
    import krbc_pkg::*;
(
    input  logic [15:0] word_in,
    input  logic [3:0]  amount,
    output logic [15:0] word_out
);

    logic [15:0] rot_w;
    logic [15:0] swap_w;
    logic [15:0] rol_w;
    logic [15:0] mix_w;

    always_comb
    begin
        rot_w    = rotr16(word_in, amount);
        swap_w   = {rot_w[7:0], ~rot_w[15:8]};
        rol_w    = {swap_w[14:0], swap_w[15]};
        mix_w    = rol_w ^ GEN_INIT;
        word_out = {mix_w[15:8], mix_w[6:0], mix_w[7]};
    end

endmodule

/* sv/keyed_rotation_byte_cipher_unit.sv */
// channel   | dir | tdata / tuser                      | accepted when
// s_axis    | in  | tdata[7:0] data_byte, tuser msg st | tvalid && tready
// m_axis    | out | tdata[7:0] out_byte                | tvalid && tready
// apb       | in  | 5 regs, 64-bit, byte addr 8*i      | psel && penable && pwrite
//
// After acceptance, an item takes one word-two mix step,
// then (word_two[4:1] + 1) passes through the shared round unit.
// s_axis_tready is high only while the sequencer is idle.
// Result sits in an output register; a new item may be taken meanwhile.
// A finished round stalls while the output register is still full.
// rst_n clears control state; key_length resets to 2, key words to 0.
module keyed_rotation_byte_cipher_unit
    import krbc_pkg::*;
#(
    parameter int unsigned KEY_MAX = KEY_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] message_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int unsigned KPOS_W = $clog2(KEY_MAX);
    localparam logic [5:0]  LEN_MAX = 6'(KEY_MAX);

    krbc_state_t state_reg, state_next;

    logic [5:0]        key_len_reg;
    logic [63:0]       key_word_reg [KEY_WORDS];
    logic [15:0]       w1_reg, w1_next;
    logic [15:0]       w2_reg, w2_next;
    logic [KPOS_W-1:0] kpos_reg, kpos_next;
    logic [4:0]        amt_reg, amt_next;
    logic [7:0]        data_reg, data_next;
    logic [7:0]        kb_reg, kb_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;

    logic [5:0]        len_used;
    logic [255:0]      key_flat;
    logic              cfg_wr;
    logic [2:0]        cfg_idx;
    logic [15:0]       w1_eff;
    logic [15:0]       w2_eff;
    logic [KPOS_W-1:0] kpos_eff;
    logic [5:0]        kpos_inc;
    logic [15:0]       mix_t;
    logic [15:0]       mix_w2;
    logic [15:0]       round_w;
    logic              in_acc;
    logic              round_last;
    logic              out_load;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[5:3];

    always_comb
    begin
        case (cfg_idx)
            REG_KEY_LENGTH: prdata = {58'd0, key_len_reg};
            REG_KEY_WORD_0: prdata = key_word_reg[0];
            REG_KEY_WORD_1: prdata = key_word_reg[1];
            REG_KEY_WORD_2: prdata = key_word_reg[2];
            REG_KEY_WORD_3: prdata = key_word_reg[3];
            default:        prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg <= KEY_LEN_RST;
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                key_word_reg[i] <= 64'd0;
            end
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_KEY_LENGTH: key_len_reg     <= pwdata[5:0];
                REG_KEY_WORD_0: key_word_reg[0] <= pwdata;
                REG_KEY_WORD_1: key_word_reg[1] <= pwdata;
                REG_KEY_WORD_2: key_word_reg[2] <= pwdata;
                REG_KEY_WORD_3: key_word_reg[3] <= pwdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (key_len_reg < KEY_LEN_MIN)
        begin
            len_used = KEY_LEN_MIN;
        end
        else if (key_len_reg > LEN_MAX)
        begin
            len_used = LEN_MAX;
        end
        else
        begin
            len_used = key_len_reg;
        end
    end

    assign key_flat = {key_word_reg[3], key_word_reg[2], key_word_reg[1], key_word_reg[0]};

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // message start reloads the generator before the byte
    always_comb
    begin
        if (s_axis_tuser)
        begin
            w1_eff   = GEN_INIT;
            w2_eff   = key_flat[15:0] ^ {10'd0, len_used};
            kpos_eff = '0;
        end
        else
        begin
            w1_eff   = w1_reg;
            w2_eff   = w2_reg;
            kpos_eff = kpos_reg;
        end
        kpos_inc = 6'(kpos_eff) + 6'd1;
    end

    always_comb
    begin
        mix_t  = {w2_reg[15:8], w2_reg[7:0] ^ w2_reg[15:8]};
        mix_w2 = (rotr16(mix_t, mix_t[3:0]) ^ w1_reg) + GEN_STEP;
    end

    krbc_round u_round
    (
        .word_in  (w1_reg),
        .amount   (amt_reg[3:0]),
        .word_out (round_w)
    );

    assign round_last = (amt_reg == 5'd1);
    assign out_load   = (state_reg == ST_ROUND) && round_last
                        && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next     = state_reg;
        w1_next        = w1_reg;
        w2_next        = w2_reg;
        kpos_next      = kpos_reg;
        amt_next       = amt_reg;
        data_next      = data_reg;
        kb_next        = kb_reg;
        out_byte_next  = out_byte_reg;
        out_valid_next = out_valid_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    w1_next   = w1_eff;
                    w2_next   = w2_eff;
                    data_next = s_axis_tdata;
                    kb_next   = key_flat[{3'd0, 5'(kpos_eff)} * 8 +: 8];
                    if (kpos_inc >= len_used)
                    begin
                        kpos_next = '0;
                    end
                    else
                    begin
                        kpos_next = kpos_inc[KPOS_W-1:0];
                    end
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                w2_next    = mix_w2;
                amt_next   = {mix_w2[4:1], 1'b1};
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (!round_last)
                begin
                    w1_next  = round_w;
                    amt_next = amt_reg - 5'd2;
                end
                else if (out_load)
                begin
                    w1_next        = round_w;
                    out_byte_next  = data_reg ^ kb_reg ^ round_w[7:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            w1_reg        <= GEN_INIT;
            w2_reg        <= 16'd0;
            kpos_reg      <= '0;
            amt_reg       <= 5'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            w1_reg        <= w1_next;
            w2_reg        <= w2_next;
            kpos_reg      <= kpos_next;
            amt_reg       <= amt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        kb_reg       <= kb_next;
        out_byte_reg <= out_byte_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;

    a_acc_to_mix: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == ST_MIX)
        else $error("accepted item did not enter mix");

    a_mix_to_round: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MIX |=> state_reg == ST_ROUND)
        else $error("mix not followed by rounds");

    a_amt_odd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND |-> amt_reg[0])
        else $error("round amount lost odd parity");

    a_out_from_round: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_ROUND && $past(round_last))
        else $error("result loaded outside final round");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND && round_last && out_valid_reg && !m_axis_tready
        |=> state_reg == ST_ROUND && $stable(w1_reg))
        else $error("final round advanced into a full output register");

endmodule

/* sim/tb_top.sv */
module tb_top
    import krbc_pkg::*;
();

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_ITEMS  = 60;
    localparam int RANDOM_PHASES = 5;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tuser;   // [0] message_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] out_byte
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    keyed_rotation_byte_cipher_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // cipher state and register shadow
    logic [15:0] gen_one;
    logic [15:0] gen_two;
    logic [4:0]  key_pos;
    logic [5:0]  cfg_len;
    logic [63:0] cfg_key [4];

    logic [7:0]  expected_out_bytes [$];
    logic [7:0]  want_byte;

    int  failures;
    int  items_sent;
    int  results_checked;
    int  reg_writes;
    int  cycle_count;
    bit  no_idle;
    int  rx_hold;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic logic [15:0] ror16(input logic [15:0] v, input logic [3:0] amt);
        return (v >> amt) | (v << ((5'd16 - amt) & 5'd15));
    endfunction

    function automatic logic [7:0] key_at(input logic [4:0] idx);
        return cfg_key[idx[4:3]][8 * idx[2:0] +: 8];
    endfunction

    function automatic logic [7:0] cipher_predict(input logic [7:0] data, input logic start);
        logic [5:0]  len;
        logic [15:0] w1;
        logic [15:0] w2;
        logic [7:0]  kb;
        int          passes;
        len = cfg_len;
        if (len < KEY_LEN_MIN)
            len = KEY_LEN_MIN;
        else if (len > KEY_MAX_DEF)
            len = 6'(KEY_MAX_DEF);
        if (start)
        begin
            gen_one = GEN_INIT;
            key_pos = '0;
            gen_two = {key_at(5'd1), key_at(5'd0)} ^ {10'd0, len};
        end
        w1 = gen_one;
        w2 = gen_two;
        kb = key_at(key_pos);
        w2 = {w2[15:8], w2[7:0] ^ w2[15:8]};
        w2 = ror16(w2, w2[3:0]);
        w2 = (w2 ^ w1) + GEN_STEP;
        gen_two = w2;
        passes = 2 * w2[4:1] + 2;
        do
        begin
            passes--;
            w1 = ror16(w1, passes[3:0]);
            w1 = {w1[7:0], w1[15:8] ^ 8'hFF};
            w1 = {w1[14:0], w1[15]};
            w1 = w1 ^ GEN_INIT;
            w1[7:0] = {w1[6:0], w1[7]};
            passes--;
        end
        while (passes != 0);
        gen_one = w1;
        if (key_pos + 1 >= len)
            key_pos = '0;
        else
            key_pos = key_pos + 5'd1;
        return data ^ kb ^ w1[7:0];
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 18);
    endfunction

    task automatic send_item(input logic [7:0] data, input logic start);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= start;
        do @(posedge clk); while (!s_axis_tready);
        expected_out_bytes.push_back(cipher_predict(data, start));
        items_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_out_bytes.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_KEY_LENGTH: cfg_len = value[5:0];
            REG_KEY_WORD_0: cfg_key[0] = value;
            REG_KEY_WORD_1: cfg_key[1] = value;
            REG_KEY_WORD_2: cfg_key[2] = value;
            REG_KEY_WORD_3: cfg_key[3] = value;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic write_key(input logic [63:0] w0, input logic [63:0] w1,
                             input logic [63:0] w2, input logic [63:0] w3);
        apb_write(REG_KEY_WORD_0, w0);
        apb_write(REG_KEY_WORD_1, w1);
        apb_write(REG_KEY_WORD_2, w2);
        apb_write(REG_KEY_WORD_3, w3);
    endtask

    // no start flag since reset: generator runs from its reset values
    task automatic test_reset_state();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_key_extremes();
        wait_idle();
        apb_write(REG_KEY_LENGTH, 64'd2);
        write_key('0, '0, '0, '0);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        wait_idle();
        apb_write(REG_KEY_LENGTH, 64'd32);
        write_key('1, '1, '1, '1);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
    endtask

    // lengths outside 2..32 are clamped
    task automatic test_length_clamp();
        logic [5:0] lens [4];
        int         k;
        lens = '{6'd0, 6'd1, 6'd33, 6'd63};
        for (k = 0; k < 4; k++)
        begin
            wait_idle();
            apb_write(REG_KEY_LENGTH, {58'd0, lens[k]});
            write_key({$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
            send_item(8'($urandom_range(0, 255)), 1'b1);
            send_item(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // position past the new length: current key byte used, then wrap to 0
    task automatic test_length_lowered();
        int k;
        wait_idle();
        apb_write(REG_KEY_LENGTH, 64'd32);
        for (k = 0; k < 10; k++)
            send_item(8'($urandom_range(0, 255)), k == 0);
        wait_idle();
        apb_write(REG_KEY_LENGTH, 64'd3);
        for (k = 0; k < 4; k++)
            send_item(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_output_stall();
        int k;
        wait_idle();
        rx_hold = 300;
        no_idle = 1'b1;
        for (k = 0; k < 24; k++)
            send_item(8'($urandom_range(0, 255)), k == 0);
        no_idle = 1'b0;
    endtask

    task automatic test_random_messages();
        int  phase;
        int  sent;
        int  msg_len;
        int  k;
        bit  opens;
        logic [5:0] len;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            if (phase == 0)
                len = 6'd2;
            else if (phase == 1)
                len = 6'd32;
            else if ($urandom_range(0, 9) == 0)
                len = 6'($urandom_range(0, 63));
            else
                len = 6'($urandom_range(2, 32));
            apb_write(REG_KEY_LENGTH, {58'd0, len});
            write_key({$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
            no_idle = (phase == 2);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 64)
                                                       : $urandom_range(1, 40);
                opens = ($urandom_range(0, 9) != 0);
                for (k = 0; k < msg_len; k++)
                begin
                    send_item(8'($urandom_range(0, 255)),
                              (k == 0 && opens) || ($urandom_range(0, 49) == 0));
                    sent++;
                end
            end
            no_idle = 1'b0;
        end
    endtask

    // receiver
    initial
    begin
        int wait_cycles;
        m_axis_tready = 1'b0;
        forever
        begin
            wait_cycles = rx_hold + draw_gap();
            rx_hold = 0;
            if (wait_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_out_bytes.size() == 0)
            begin
                $error("out_byte: no item expected, actual %02h", m_axis_tdata);
                failures++;
            end
            else
            begin
                want_byte = expected_out_bytes.pop_front();
                if (m_axis_tdata !== want_byte)
                begin
                    $error("out_byte: expected %02h, actual %02h", want_byte, m_axis_tdata);
                    failures++;
                end
            end
            results_checked++;
        end
    end

    initial
    begin
        failures        = 0;
        items_sent      = 0;
        results_checked = 0;
        reg_writes      = 0;
        cycle_count     = 0;
        no_idle         = 1'b0;
        rx_hold         = 0;
        gen_one         = GEN_INIT;
        gen_two         = '0;
        key_pos         = '0;
        cfg_len         = KEY_LEN_RST;
        cfg_key         = '{default: '0};
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_key_extremes();
        test_length_clamp();
        test_length_lowered();
        test_output_stall();
        test_random_messages();
        wait_idle();

        $display("%0d items sent, %0d results checked, %0d register writes",
                 items_sent, results_checked, reg_writes);
        $display("covered reset state, key extremes, length clamp and drop, %s",
                 "output stall, random messages");
        if (failures == 0 && expected_out_bytes.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
